@@ rtl/prms_pkg.sv @@
package prms_pkg;

    localparam int SLOTS       = 16;
    localparam int MATCH_BYTES = 12;
    localparam int TOTAL       = 2 * SLOTS;
    localparam int IW          = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int JW          = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int AW          = (SLOTS * MATCH_BYTES > 1) ? $clog2(SLOTS * MATCH_BYTES) : 1;
    localparam int FLW         = $clog2(MATCH_BYTES + 1);

    localparam logic [3:0] CMD_ALLOC    = 4'd0;
    localparam logic [3:0] CMD_FIND     = 4'd1;
    localparam logic [3:0] CMD_LOAD     = 4'd2;
    localparam logic [3:0] CMD_LDBYTE   = 4'd3;
    localparam logic [3:0] CMD_SELECT   = 4'd4;
    localparam logic [3:0] CMD_RXBYTE   = 4'd5;
    localparam logic [3:0] CMD_EXPIRE   = 4'd6;
    localparam logic [3:0] CMD_SENT     = 4'd7;
    localparam logic [3:0] CMD_COMPLETE = 4'd8;
    localparam logic [3:0] CMD_DEFER    = 4'd9;
    localparam logic [3:0] CMD_DROP     = 4'd10;

    localparam logic [1:0] KIND_PERIODIC = 2'd0;
    localparam logic [1:0] KIND_UNTIL    = 2'd1;
    localparam logic [1:0] KIND_WHILE    = 2'd2;

    typedef struct packed {
        logic [3:0]  command;
        logic [4:0]  slot;
        logic [31:0] job_id;
        logic [1:0]  option;
        logic [1:0]  kind;
        logic [31:0] time_us;
        logic [31:0] time2_us;
        logic [31:0] spacing_us;
        logic [3:0]  byte_index;
        logic [7:0]  data_byte;
        logic [7:0]  mask_byte;
        logic [31:0] frame_flags;
    } t_in_item;

    typedef struct packed {
        logic       found;
        logic [4:0] slot_index;
    } t_out_item;

    typedef enum logic [4:0] {
        STEP_NONE,
        STEP_ALLOC,
        STEP_FIND,
        STEP_SELECT,
        STEP_CLAIM,
        STEP_LOAD,
        STEP_LDBYTE,
        STEP_RX_RD,
        STEP_RX_CMP,
        STEP_RX_LEN,
        STEP_FRAME,
        STEP_FRAME_END,
        STEP_EXPIRE,
        STEP_SENT_A,
        STEP_SENT_B,
        STEP_COMPLETE,
        STEP_DEFER,
        STEP_DROP
    } t_step;

    typedef struct packed {
        logic            load;
        t_step           step;
        logic [IW-1:0]   idx;
    } t_ctl;

    typedef struct packed {
        logic            found;
        logic [IW-1:0]   best;
        logic            go_sent;
    } t_stat;

    // a is at or after b, modulo 2^32
    function automatic logic not_earlier(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return !d[31];
    endfunction

endpackage

@@ rtl/prms_if.sv @@
interface prms_in_if;
    import prms_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface prms_out_if;
    import prms_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/prms_dp.sv @@
module prms_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  prms_pkg::t_in_item i_item,
    input  prms_pkg::t_ctl     i_ctl,
    output prms_pkg::t_stat    o_stat
);
    import prms_pkg::*;

    localparam logic [7:0] MB8 = 8'(MATCH_BYTES);

    // reset-cleared table state
    logic [31:0]      r_ident [TOTAL];
    logic [1:0]       r_kind  [TOTAL];
    logic [TOTAL-1:0] r_active, r_pending, r_sent, r_ended_f, r_have, r_matched;
    logic [SLOTS-1:0] r_mismatch;
    logic [FLW-1:0]   r_flen;
    logic             r_found;
    logic [IW-1:0]    r_best;

    // undefined-until-written state
    logic [31:0] r_due     [TOTAL];
    logic [31:0] r_created [TOTAL];
    logic [31:0] r_ended   [TOTAL];
    logic [31:0] r_match_t [TOTAL];
    logic [31:0] r_period  [TOTAL];
    logic [3:0]  r_plen    [TOTAL];
    logic [31:0] r_pflags  [TOTAL];
    logic [15:0] r_mem     [SLOTS * MATCH_BYTES];
    logic [15:0] r_rd;
    t_in_item    r_it;
    logic [31:0] r_bdue, r_bid;
    logic        r_skip;

    logic          slot_ok;
    logic [IW-1:0] a;
    logic [JW-1:0] j;
    logic          bi_ok, single;
    logic [AW-1:0] rd_addr, wr_addr;
    logic          elig, better, match, n_skip;
    logic [31:0]   n_due;
    logic [3:0]    sat_len;

    assign slot_ok = 6'(r_it.slot) < 6'(TOTAL);
    assign single  = (i_ctl.step == STEP_LOAD) || (i_ctl.step == STEP_LDBYTE) ||
                     (i_ctl.step == STEP_SENT_A) || (i_ctl.step == STEP_SENT_B) ||
                     (i_ctl.step == STEP_COMPLETE) || (i_ctl.step == STEP_DEFER);
    assign a       = single ? IW'(r_it.slot) : i_ctl.idx;
    assign j       = JW'(a - IW'(SLOTS));
    assign bi_ok   = 8'(r_it.byte_index) < MB8;
    assign rd_addr = AW'(32'(j) * MATCH_BYTES + (bi_ok ? 32'(r_it.byte_index) : 32'd0));
    assign wr_addr = AW'(32'(JW'(IW'(r_it.slot) - IW'(SLOTS))) * MATCH_BYTES
                         + 32'(r_it.byte_index));
    assign sat_len = (8'(r_it.byte_index) > MB8) ? 4'(MATCH_BYTES) : r_it.byte_index;

    always_comb begin
        elig   = r_active[a] && !r_pending[a] && not_earlier(r_it.time_us, r_due[a]) &&
                 (r_it.option[0] || r_kind[a] == KIND_PERIODIC);
        better = !r_found || !not_earlier(r_due[a], r_bdue) ||
                 (r_due[a] == r_bdue && !not_earlier(r_ident[a], r_bid));
        match  = (8'(r_flen) >= 8'(r_plen[a])) && (r_it.frame_flags == r_pflags[a]) &&
                 !r_mismatch[j];
        n_skip = !slot_ok || (r_ended_f[a] && r_ended[a] == r_it.time2_us);
        n_due  = ((r_kind[a] == KIND_PERIODIC) ? r_it.time_us : r_it.time2_us) + r_period[a];
    end

    assign o_stat.found   = r_found;
    assign o_stat.best    = r_best;
    assign o_stat.go_sent = slot_ok && (r_it.option[0] || r_kind[a] == KIND_PERIODIC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TOTAL; i++) begin
                r_ident[i] <= '0;
                r_kind[i]  <= '0;
            end
            r_active   <= '0;
            r_pending  <= '0;
            r_sent     <= '0;
            r_ended_f  <= '0;
            r_have     <= '0;
            r_matched  <= '0;
            r_mismatch <= '0;
            r_flen     <= '0;
            r_found    <= 1'b0;
            r_best     <= '0;
        end else if (i_ctl.load) begin
            r_found <= 1'b0;
            r_best  <= '0;
        end else begin
            unique case (i_ctl.step)
                STEP_ALLOC: begin
                    if (!r_found && r_ident[a] == 32'd0) begin
                        r_found <= 1'b1;
                        r_best  <= a;
                    end
                end
                STEP_FIND: begin
                    if (r_it.job_id != 32'd0 && !r_found && r_ident[a] == r_it.job_id) begin
                        r_found <= 1'b1;
                        r_best  <= a;
                    end
                end
                STEP_SELECT: begin
                    if (elig && better) begin
                        r_found <= 1'b1;
                        r_best  <= a;
                    end
                end
                STEP_CLAIM: begin
                    if (r_found && r_it.option[1]) r_pending[r_best] <= 1'b1;
                end
                STEP_LOAD: begin
                    if (slot_ok) begin
                        r_ident[a]   <= r_it.job_id;
                        r_kind[a]    <= r_it.kind;
                        r_active[a]  <= r_it.job_id != 32'd0;
                        r_pending[a] <= 1'b0;
                        r_sent[a]    <= 1'b0;
                        r_ended_f[a] <= 1'b0;
                        r_have[a]    <= 1'b0;
                        r_matched[a] <= 1'b0;
                    end
                end
                STEP_RX_CMP: begin
                    if (bi_ok && r_it.byte_index < r_plen[a] &&
                        (r_it.data_byte & r_rd[15:8]) != r_rd[7:0])
                        r_mismatch[j] <= 1'b1;
                end
                STEP_RX_LEN: begin
                    if (8'(r_flen) < MB8) r_flen <= r_flen + 1'b1;
                end
                STEP_FRAME: begin
                    if (r_active[a] && not_earlier(r_it.time_us, r_created[a])) begin
                        if ((r_kind[a] == KIND_UNTIL && match) ||
                            (r_kind[a] == KIND_WHILE && !match)) begin
                            r_active[a] <= 1'b0;
                        end else if (match) begin
                            r_have[a] <= 1'b1;
                            if (r_sent[a] && not_earlier(r_it.time_us, r_ended[a]) &&
                                not_earlier(r_due[a], r_it.time_us))
                                r_matched[a] <= 1'b1;
                        end
                    end
                end
                STEP_FRAME_END: begin
                    r_mismatch <= '0;
                    r_flen     <= '0;
                end
                STEP_EXPIRE: begin
                    if (r_active[a] && r_kind[a] == KIND_WHILE && r_sent[a] &&
                        (!r_pending[a] || r_ended_f[a]) && !r_matched[a] &&
                        not_earlier(r_it.time_us, r_due[a]))
                        r_active[a] <= 1'b0;
                end
                STEP_SENT_A: begin
                    if (!n_skip) begin
                        r_ended_f[a] <= 1'b1;
                        r_sent[a]    <= 1'b1;
                    end
                end
                STEP_SENT_B: begin
                    if (!r_skip)
                        r_matched[a] <= r_have[a] && not_earlier(r_match_t[a], r_it.time2_us)
                                        && not_earlier(r_due[a], r_match_t[a]);
                end
                STEP_COMPLETE: begin
                    if (slot_ok) begin
                        r_pending[a] <= 1'b0;
                        if (!r_it.option[0] && r_kind[a] != KIND_PERIODIC)
                            r_active[a] <= 1'b0;
                    end
                end
                STEP_DEFER: begin
                    if (slot_ok) r_pending[a] <= 1'b0;
                end
                STEP_DROP: begin
                    r_active[TOTAL-1:SLOTS] <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) r_it <= i_item;
        r_rd <= r_mem[rd_addr];
        unique case (i_ctl.step)
            STEP_SELECT: begin
                if (elig && better) begin
                    r_bdue <= r_due[a];
                    r_bid  <= r_ident[a];
                end
            end
            STEP_LOAD: begin
                if (slot_ok) begin
                    r_created[a] <= r_it.time_us;
                    r_due[a]     <= r_it.time2_us;
                    r_period[a]  <= r_it.spacing_us;
                    r_plen[a]    <= sat_len;
                    r_pflags[a]  <= r_it.frame_flags;
                end
            end
            STEP_LDBYTE: begin
                if (slot_ok && 6'(r_it.slot) >= 6'(SLOTS) && bi_ok)
                    r_mem[wr_addr] <= {r_it.mask_byte, r_it.data_byte};
            end
            STEP_FRAME: begin
                if (r_active[a] && not_earlier(r_it.time_us, r_created[a]) && match &&
                    !(r_kind[a] == KIND_UNTIL) && !(r_kind[a] == KIND_WHILE && !match))
                    r_match_t[a] <= r_it.time_us;
            end
            STEP_SENT_A: begin
                r_skip <= n_skip;
                if (!n_skip) begin
                    r_ended[a] <= r_it.time2_us;
                    r_due[a]   <= n_due;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

@@ rtl/prms_ctrl.sv @@
module prms_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    prms_in_if.sink         i_in,
    prms_out_if.source      o_out,
    input  prms_pkg::t_stat i_stat,
    output prms_pkg::t_ctl  o_ctl
);
    import prms_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_CLAIM, S_RX_RD, S_RX_CMP, S_RX_LEN,
        S_FRAME, S_FRAME_END, S_SINGLE, S_SENT_A, S_SENT_B, S_FINISH
    } t_state;

    t_state        r_state;
    logic [IW-1:0] r_idx, r_end;
    logic [3:0]    r_cmd;
    logic [1:0]    r_opt;
    logic          r_ovalid;
    t_out_item     r_odata;
    logic          accept;

    assign i_in.ready  = (r_state == S_IDLE);
    assign accept      = i_in.valid && i_in.ready;
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_odata;

    always_comb begin
        o_ctl.load = accept;
        o_ctl.idx  = r_idx;
        unique case (r_state)
            S_SCAN: begin
                priority if (r_cmd == CMD_ALLOC)  o_ctl.step = STEP_ALLOC;
                else if (r_cmd == CMD_FIND)       o_ctl.step = STEP_FIND;
                else if (r_cmd == CMD_SELECT)     o_ctl.step = STEP_SELECT;
                else                              o_ctl.step = STEP_EXPIRE;
            end
            S_CLAIM:     o_ctl.step = STEP_CLAIM;
            S_RX_RD:     o_ctl.step = STEP_RX_RD;
            S_RX_CMP:    o_ctl.step = STEP_RX_CMP;
            S_RX_LEN:    o_ctl.step = STEP_RX_LEN;
            S_FRAME:     o_ctl.step = STEP_FRAME;
            S_FRAME_END: o_ctl.step = STEP_FRAME_END;
            S_SINGLE: begin
                priority if (r_cmd == CMD_LOAD)   o_ctl.step = STEP_LOAD;
                else if (r_cmd == CMD_LDBYTE)     o_ctl.step = STEP_LDBYTE;
                else if (r_cmd == CMD_COMPLETE)   o_ctl.step = STEP_COMPLETE;
                else if (r_cmd == CMD_DEFER)      o_ctl.step = STEP_DEFER;
                else                              o_ctl.step = STEP_DROP;
            end
            S_SENT_A:    o_ctl.step = STEP_SENT_A;
            S_SENT_B:    o_ctl.step = STEP_SENT_B;
            default:     o_ctl.step = STEP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_end    <= '0;
            r_cmd    <= '0;
            r_opt    <= '0;
            r_ovalid <= 1'b0;
            r_odata  <= '0;
        end else begin
            // in S_FINISH the output register is handled below
            if (r_ovalid && o_out.ready && r_state != S_FINISH) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cmd <= i_in.data.command;
                        r_opt <= i_in.data.option;
                        unique case (i_in.data.command)
                            CMD_ALLOC: begin
                                r_idx   <= i_in.data.option[0] ? IW'(SLOTS) : '0;
                                r_end   <= i_in.data.option[0] ? IW'(TOTAL - 1) : IW'(SLOTS - 1);
                                r_state <= S_SCAN;
                            end
                            CMD_FIND, CMD_SELECT: begin
                                r_idx   <= '0;
                                r_end   <= IW'(TOTAL - 1);
                                r_state <= S_SCAN;
                            end
                            CMD_EXPIRE: begin
                                r_idx   <= IW'(SLOTS);
                                r_end   <= IW'(TOTAL - 1);
                                r_state <= S_SCAN;
                            end
                            CMD_RXBYTE: begin
                                r_idx   <= IW'(SLOTS);
                                r_end   <= IW'(TOTAL - 1);
                                r_state <= S_RX_RD;
                            end
                            CMD_LOAD, CMD_LDBYTE, CMD_COMPLETE, CMD_DEFER, CMD_DROP:
                                r_state <= S_SINGLE;
                            CMD_SENT: r_state <= S_SENT_A;
                            default:  r_state <= S_FINISH;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_idx == r_end)
                        r_state <= (r_cmd == CMD_SELECT && r_opt[1]) ? S_CLAIM : S_FINISH;
                    else
                        r_idx <= r_idx + 1'b1;
                end
                S_CLAIM:  r_state <= S_FINISH;
                S_RX_RD:  r_state <= S_RX_CMP;
                S_RX_CMP: begin
                    if (r_idx == r_end) begin
                        r_state <= S_RX_LEN;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_RX_RD;
                    end
                end
                S_RX_LEN: begin
                    r_idx   <= IW'(SLOTS);
                    r_state <= r_opt[0] ? S_FRAME : S_FINISH;
                end
                S_FRAME: begin
                    if (r_idx == r_end) r_state <= S_FRAME_END;
                    else                r_idx <= r_idx + 1'b1;
                end
                S_FRAME_END: r_state <= S_FINISH;
                S_SINGLE: begin
                    r_state <= (r_cmd == CMD_COMPLETE && i_stat.go_sent) ? S_SENT_A : S_FINISH;
                end
                S_SENT_A: r_state <= S_SENT_B;
                S_SENT_B: r_state <= S_FINISH;
                S_FINISH: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_ovalid             <= 1'b1;
                        r_odata.found        <= i_stat.found;
                        r_odata.slot_index   <= i_stat.found ? 5'(i_stat.best) : 5'd0;
                        r_state              <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ rtl/periodic_and_repeat_message_scheduler_unit.sv @@
// channel  | dir | handshake     | payload
// i_in     | in  | valid / ready | command, slot, job_id, option, kind, times, bytes, flags
// o_out    | out | valid / ready | found, slot_index
//
// One command at a time. Allocate, find, select and expire scan the job table slot by
// slot (select with claim adds a claim step); receive byte compares each pattern slot
// and, on the last byte, adds a frame pass over the pattern slots.
// Synchronous active-low reset frees every slot and clears the frame state.
// A finished result sits in the output register, so the next transaction is taken
// while o_out is stalled; a second result then waits until the first is taken.
module periodic_and_repeat_message_scheduler_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    prms_in_if.sink    i_in,
    prms_out_if.source o_out
);
    import prms_pkg::*;

    t_ctl  ctl;
    t_stat stat;

    prms_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_stat  (stat),
        .o_ctl   (ctl)
    );

    prms_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_in.data),
        .i_ctl   (ctl),
        .o_stat  (stat)
    );

endmodule
